// File: hdl/aik_pkg.sv
// Shared constants, widths and helpers for the arm inverse kinematics block.
// No dependencies; imported by every module of the block.
package aik_pkg;

  localparam int LEN_W = 23;           // link and base height registers
  localparam int DEN_W = 2 * LEN_W + 1;
  localparam int WFRAC = 30;           // internal angle and ratio fraction bits
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = 2;

  localparam logic signed [32:0] PI_W      = 33'sd3373259426;
  localparam logic signed [32:0] HALF_PI_W = 33'sd1686629713;

  localparam logic [1:0] CFG_BASE_HEIGHT = 2'd0;
  localparam logic [1:0] CFG_UPPER_LINK  = 2'd1;
  localparam logic [1:0] CFG_LOWER_LINK  = 2'd2;
  localparam logic [1:0] CFG_MODE        = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNREACH   = 2'd1;
  localparam logic [1:0] ST_OUT_RANGE = 2'd2;

  function automatic int zo_w(input int cb);
    zo_w = ((cb > LEN_W) ? cb : LEN_W) + 1;
  endfunction

  // x, y, zo, m, num, den, unreachable, mode, l2, l3
  function automatic int entry_w(input int cb);
    entry_w = 2 * cb + zo_w(cb) + (2 * cb + 1) + (2 * zo_w(cb) + 3) + DEN_W + 2 + 2 * LEN_W;
  endfunction

  // atan(2^-i) in Q30; beyond the table the small-angle form 2^-i holds
  function automatic logic [31:0] atan_step(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'd843314856;
      1: v = 32'd497837829;
      2: v = 32'd263043836;
      3: v = 32'd133525158;
      4: v = 32'd67021686;
      5: v = 32'd33543515;
      6: v = 32'd16775850;
      7: v = 32'd8388437;
      8: v = 32'd4194282;
      9: v = 32'd2097149;
      default: begin
        if (i <= WFRAC) v = 32'((64'd1 << (WFRAC - i)) - 64'd1);
        else v = 32'd0;
      end
    endcase
    atan_step = v;
  endfunction

endpackage

// File: hdl/aik_front.sv
// Front end: configuration registers, target intake and squared-distance classification.
// Depends on aik_pkg; feeds aik_queue.
module aik_front #(
  parameter int COORD_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  config_write,
  input  logic [1:0]                            config_index,
  input  logic [aik_pkg::LEN_W-1:0]             config_data,
  input  logic signed [COORD_BITS-1:0]          target_x,
  input  logic signed [COORD_BITS-1:0]          target_y,
  input  logic signed [COORD_BITS-1:0]          target_z,
  input  logic                                  target_valid,
  output logic                                  target_ready,
  output logic                                  push_valid,
  input  logic                                  push_ready,
  output logic [aik_pkg::entry_w(COORD_BITS)-1:0] push_data
);
  import aik_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int ZW = zo_w(C);
  localparam int MW = 2 * C + 1;
  localparam int DW = 2 * ZW + 2;
  localparam int LW = LEN_W;

  logic [LW-1:0] base_height, upper_len, lower_len;
  logic          mode;

  logic adv;
  logic v1, v2, v3, v4;
  logic signed [C-1:0]  x1, y1, x2, y2, x3, y3, x4, y4;
  logic signed [ZW-1:0] zo1, zo2, zo3, zo4;
  logic [LW-1:0] l2_1, l3_1, l2_2, l3_2, l2_3, l3_3, l2_4, l3_4;
  logic mode1, mode2, mode3, mode4;
  logic [C-1:0]  ux, uy;
  logic [ZW-1:0] uz;
  logic [2*C-1:0]  ux2, uy2;
  logic [2*ZW-1:0] uz2_2, uz2_3;
  logic [2*LW-1:0] l2sq, l3sq, l23;
  logic [MW-1:0] m3, m4;
  logic [DEN_W-1:0] lsum3, den3, lsum4, den4, lo4;
  logic [DEN_W:0] hi4;
  logic [DW-1:0] d2;
  logic signed [DW:0] num;
  logic unreach;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_height <= '0;
      upper_len   <= LW'(4096);
      lower_len   <= LW'(4096);
      mode        <= 1'b0;
    end else if (config_write) begin
      case (config_index)
        CFG_BASE_HEIGHT: base_height <= config_data;
        CFG_UPPER_LINK:  upper_len   <= config_data;
        CFG_LOWER_LINK:  lower_len   <= config_data;
        CFG_MODE:        mode        <= config_data[0];
        default: ;
      endcase
    end
  end

  assign adv = !v4 || push_ready;
  assign target_ready = adv;

  assign ux = x1[C-1] ? C'(-x1) : C'(x1);
  assign uy = y1[C-1] ? C'(-y1) : C'(y1);
  assign uz = zo1[ZW-1] ? ZW'(-zo1) : ZW'(zo1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= target_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1    <= target_x;
      y1    <= target_y;
      zo1   <= ZW'(target_z) - ZW'(base_height);
      l2_1  <= upper_len;
      l3_1  <= lower_len;
      mode1 <= mode;

      ux2   <= (2*C)'(ux) * (2*C)'(ux);
      uy2   <= (2*C)'(uy) * (2*C)'(uy);
      uz2_2 <= (2*ZW)'(uz) * (2*ZW)'(uz);
      l2sq  <= (2*LW)'(l2_1) * (2*LW)'(l2_1);
      l3sq  <= (2*LW)'(l3_1) * (2*LW)'(l3_1);
      l23   <= (2*LW)'(l2_1) * (2*LW)'(l3_1);
      x2 <= x1; y2 <= y1; zo2 <= zo1; l2_2 <= l2_1; l3_2 <= l3_1; mode2 <= mode1;

      m3    <= MW'(ux2) + MW'(uy2);
      lsum3 <= DEN_W'(l2sq) + DEN_W'(l3sq);
      den3  <= {l23, 1'b0};
      uz2_3 <= uz2_2;
      x3 <= x2; y3 <= y2; zo3 <= zo2; l2_3 <= l2_2; l3_3 <= l3_2; mode3 <= mode2;

      d2    <= DW'(m3) + DW'(uz2_3);
      hi4   <= (DEN_W+1)'(lsum3) + (DEN_W+1)'(den3);
      lo4   <= lsum3 - den3;            // (l2 - l3)^2, never negative
      lsum4 <= lsum3;
      den4  <= den3;
      m4    <= m3;
      x4 <= x3; y4 <= y3; zo4 <= zo3; l2_4 <= l2_3; l3_4 <= l3_3; mode4 <= mode3;
    end
  end

  assign num = $signed((DW+1)'(d2)) - $signed((DW+1)'(lsum4));
  assign unreach = (l2_4 == '0) || (l3_4 == '0) || (d2 > DW'(hi4)) || (d2 < DW'(lo4));

  assign push_valid = v4;
  assign push_data  = {x4, y4, zo4, m4, num, den4, unreach, mode4, l2_4, l3_4};

endmodule

// File: hdl/aik_queue.sv
// Short FIFO between the classifying front end and the solver back end.
// Depends on aik_pkg for depth constants.
module aik_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop,
  output logic [W-1:0] pop_data
);
  import aik_pkg::*;

  logic [W-1:0]    mem [Q_DEPTH];
  logic [Q_AW-1:0] wp, rp;
  logic [Q_AW:0]   count;
  logic do_push, do_pop;

  assign push_ready = (count != (Q_AW+1)'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = mem[rp];

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (do_push) wp <= wp + 1'b1;
      if (do_pop) rp <= rp + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

endmodule

// File: hdl/aik_cordic.sv
// Iterative vectoring CORDIC giving atan2(y, x) in Q30 radians, one rotation a cycle.
// Depends on aik_pkg for the arctangent table and pi constants.
module aik_cordic #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] y,
  input  logic signed [63:0] x,
  output logic               done,
  output logic signed [32:0] angle
);
  import aik_pkg::*;

  localparam int IW = $clog2(STEPS);

  typedef enum logic [2:0] {C_IDLE, C_CHK, C_NORM, C_ROT, C_FIN} cstate_t;
  cstate_t state;

  logic [63:0] ax, ay, orv;
  logic xneg, yneg;
  logic signed [63:0] xr, yr, xs, ys;
  logic signed [33:0] z, at, z_next;
  logic [IW-1:0] i;
  logic signed [32:0] raw, mapped;

  assign orv = ax | ay;
  assign xs  = xr >>> i;
  assign ys  = yr >>> i;
  assign at  = $signed({2'b00, atan_step(int'(i))});
  assign z_next = yr[63] ? z - at : z + at;
  assign mapped = xneg ? PI_W - raw : raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            ax   <= x[63] ? 64'(-x) : 64'(x);
            ay   <= y[63] ? 64'(-y) : 64'(y);
            xneg <= x[63];
            yneg <= y[63];
            state <= C_CHK;
          end
        end
        C_CHK: begin
          if (ay == '0) begin
            raw <= '0;
            state <= C_FIN;
          end else if (ax == '0) begin
            raw <= HALF_PI_W;
            state <= C_FIN;
          end else begin
            state <= C_NORM;
          end
        end
        C_NORM: begin
          // bring the larger magnitude into [2^59, 2^60)
          if (orv[59]) begin
            xr <= $signed(ax);
            yr <= $signed(ay);
            z  <= '0;
            i  <= '0;
            state <= C_ROT;
          end else if (orv[59:52] == '0) begin
            ax <= ax << 8;
            ay <= ay << 8;
          end else begin
            ax <= ax << 1;
            ay <= ay << 1;
          end
        end
        C_ROT: begin
          if (!yr[63]) begin
            xr <= xr + ys;
            yr <= yr - xs;
          end else begin
            xr <= xr - ys;
            yr <= yr + xs;
          end
          z <= z_next;
          i <= i + 1'b1;
          if (i == IW'(STEPS - 1)) begin
            if (z_next < 0) raw <= '0;
            else if (z_next > 34'(HALF_PI_W)) raw <= HALF_PI_W;
            else raw <= 33'(z_next);
            state <= C_FIN;
          end
        end
        C_FIN: begin
          angle <= yneg ? -mapped : mapped;
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/aik_isqrt.sv
// Bit-pair integer square root, floor(sqrt(n)) of a 64-bit value.
// Depends on nothing beyond the package import convention.
module aik_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] n,
  output logic        done,
  output logic [31:0] root
);
  import aik_pkg::*;

  typedef enum logic {Q_IDLE, Q_RUN} qstate_t;
  qstate_t state;

  logic [63:0] rem, res, bitv, trial, res_next;
  logic [4:0]  j;
  logic take;

  assign bitv  = 64'd1 << {j, 1'b0};
  assign trial = res + bitv;
  assign take  = rem >= trial;
  assign res_next = take ? (res >> 1) + bitv : res >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Q_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        Q_IDLE: begin
          if (start) begin
            rem <= n;
            res <= '0;
            j   <= 5'd31;
            state <= Q_RUN;
          end
        end
        Q_RUN: begin
          if (take) rem <= rem - trial;
          res <= res_next;
          j <= j - 1'b1;
          if (j == '0) begin
            root  <= res_next[31:0];
            done  <= 1'b1;
            state <= Q_IDLE;
          end
        end
        default: state <= Q_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/aik_back.sv
// Back end: sequencer over a shared CORDIC, square root, divider and multiplier,
// with the result register. Depends on aik_pkg, aik_cordic and aik_isqrt.
module aik_back #(
  parameter int CORDIC_STEPS = 16,
  parameter int COORD_BITS   = 24,
  parameter int ANGLE_BITS   = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_valid,
  output logic                                   q_pop,
  input  logic [aik_pkg::entry_w(COORD_BITS)-1:0] q_data,
  output logic                                   result_valid,
  input  logic                                   result_ready,
  output logic [1:0]                             status,
  output logic signed [ANGLE_BITS-1:0]           base_angle,
  output logic signed [ANGLE_BITS-1:0]           shoulder_angle,
  output logic signed [ANGLE_BITS-1:0]           elbow_angle,
  output logic                                   elbow_up,
  output logic                                   last
);
  import aik_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int ZW = zo_w(C);
  localparam int MW = 2 * C + 1;
  localparam int DW = 2 * ZW + 2;
  localparam int EW = entry_w(C);
  localparam int AB = ANGLE_BITS;
  localparam int QW = 36;
  localparam int QSH = WFRAC - (AB - 3);
  localparam logic signed [QW-1:0] QHALF = QW'(64'd1 << (QSH - 1));
  localparam logic signed [QW-1:0] PIA   = QW'((64'd3373259426 + (64'd1 << (QSH - 1))) >> QSH);
  localparam logic signed [QW-1:0] HI    = QW'((64'd1 << (AB - 1)) - 64'd1);
  localparam logic signed [QW-1:0] LO    = -HI - QW'(1);

  typedef enum logic [4:0] {
    S_IDLE, S_BASE_GO, S_BASE_W, S_DIV, S_KN, S_QQ, S_SQ_GO, S_SQ_W,
    S_T3_GO, S_T3_W, S_R_GO, S_R_W, S_AL_GO, S_AL_W, S_M1, S_M2, S_M3,
    S_BE_GO, S_BE_W, S_FIN, S_OUT1, S_OUT2
  } bstate_t;
  bstate_t state;

  function automatic logic signed [QW-1:0] quant(input logic signed [QW-1:0] v);
    quant = (v + QHALF) >>> QSH;
  endfunction

  function automatic logic [AB-1:0] sat(input logic signed [QW-1:0] v);
    if (v > HI) sat = HI[AB-1:0];
    else if (v < LO) sat = LO[AB-1:0];
    else sat = v[AB-1:0];
  endfunction

  logic [EW-1:0] ent;
  logic signed [C-1:0]  ex, ey;
  logic signed [ZW-1:0] ezo;
  logic [MW-1:0]        em;
  logic signed [DW:0]   enm;
  logic [DEN_W-1:0]     eden;
  logic eunr, emode;
  logic [LEN_W-1:0] el2, el3;

  logic [DW-1:0] un;
  logic [DW:0]   rem, rem2;
  logic [WFRAC:0] q;
  logic qneg;
  logic [4:0] cnt, k;
  logic [63:0] mm;
  logic [31:0] s, r;
  logic signed [32:0] t3, alpha, beta;
  logic signed [63:0] by, bx, c64, zs;
  logic [WFRAC:0] mul_a, mul_b;
  logic [2*WFRAC+1:0] prod;
  logic signed [QW-1:0] qa1, qa2, qa3, qa2u, qa3u;
  logic out_free, out_range, out_load;

  logic c_start, c_done;
  logic signed [63:0] c_y, c_x;
  logic signed [32:0] c_angle;
  logic s_start, s_done;
  logic [63:0] s_n;
  logic [31:0] s_root;

  assign {ex, ey, ezo, em, enm, eden, eunr, emode, el2, el3} = ent;

  assign un   = enm[DW] ? DW'(-enm) : DW'(enm);
  assign rem2 = rem << 1;
  assign c64  = qneg ? -$signed(64'(q)) : $signed(64'(q));
  assign zs   = 64'(ezo) <<< k;
  assign out_free = !result_valid || result_ready;
  assign out_load = (state == S_OUT1 || state == S_OUT2) && out_free;
  assign out_range = (qa1 > PIA) || (qa1 < -PIA) || (qa2 > PIA) || (qa2 < -PIA)
                  || (qa3 > PIA) || (qa3 < -PIA);
  assign q_pop = (state == S_IDLE) && q_valid;

  always_comb begin
    c_start = 1'b0;
    c_y = '0;
    c_x = '0;
    case (state)
      S_BASE_GO: begin c_start = 1'b1; c_y = 64'(ey); c_x = 64'(ex); end
      S_T3_GO:   begin c_start = 1'b1; c_y = $signed({32'd0, s}); c_x = c64; end
      S_AL_GO:   begin c_start = 1'b1; c_y = zs; c_x = $signed({32'd0, r}); end
      S_BE_GO:   begin c_start = 1'b1; c_y = by; c_x = bx; end
      default: ;
    endcase
  end

  always_comb begin
    s_start = 1'b0;
    s_n = '0;
    case (state)
      S_SQ_GO: begin s_start = 1'b1; s_n = (64'd1 << 60) - 64'(prod); end
      S_R_GO:  begin s_start = 1'b1; s_n = mm; end
      default: ;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_QQ: begin mul_a = q; mul_b = q; end
      S_M1: begin mul_a = s[WFRAC:0]; mul_b = (WFRAC+1)'(el3); end
      S_M2: begin mul_a = q; mul_b = (WFRAC+1)'(el3); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= (2*WFRAC+2)'(mul_a) * (2*WFRAC+2)'(mul_b);
  end

  aik_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(c_start), .y(c_y), .x(c_x),
    .done(c_done), .angle(c_angle)
  );

  aik_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(s_start), .n(s_n), .done(s_done), .root(s_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_ready && !out_load) result_valid <= 1'b0;
      // k normalisation of x^2 + y^2 overlaps the division
      if ((state == S_DIV || state == S_KN) && k < 5'd16 && mm[63:56] == '0) begin
        mm <= mm << 2;
        k  <= k + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            ent <= q_data;
            state <= S_BASE_GO;
          end
        end
        S_BASE_GO: state <= S_BASE_W;
        S_BASE_W: begin
          if (c_done) begin
            qa1 <= quant(QW'(c_angle));
            mm <= 64'(em);
            k  <= '0;
            rem <= (DW+1)'(un);
            qneg <= enm[DW];
            cnt <= '0;
            if (eunr) begin
              state <= S_OUT1;
            end else if (un >= DW'(eden)) begin
              q <= (WFRAC+1)'(64'd1 << WFRAC);
              state <= S_KN;
            end else begin
              q <= '0;
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (rem2 >= (DW+1)'(eden)) begin
            rem <= rem2 - (DW+1)'(eden);
            q <= {q[WFRAC-1:0], 1'b1};
          end else begin
            rem <= rem2;
            q <= {q[WFRAC-1:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 5'(WFRAC - 1)) state <= S_KN;
        end
        S_KN: begin
          if (!(k < 5'd16 && mm[63:56] == '0)) state <= S_QQ;
        end
        S_QQ:    state <= S_SQ_GO;
        S_SQ_GO: state <= S_SQ_W;
        S_SQ_W: begin
          if (s_done) begin
            s <= s_root;
            state <= S_T3_GO;
          end
        end
        S_T3_GO: state <= S_T3_W;
        S_T3_W: begin
          if (c_done) begin
            t3 <= c_angle;
            state <= S_R_GO;
          end
        end
        S_R_GO: state <= S_R_W;
        S_R_W: begin
          if (s_done) begin
            r <= s_root;
            state <= S_AL_GO;
          end
        end
        S_AL_GO: state <= S_AL_W;
        S_AL_W: begin
          if (c_done) begin
            alpha <= c_angle;
            state <= S_M1;
          end
        end
        S_M1: state <= S_M2;
        S_M2: begin
          by <= $signed(64'(prod));
          state <= S_M3;
        end
        S_M3: begin
          bx <= $signed(64'(el3) - 64'(el3) + (64'(el2) << WFRAC))
              + (qneg ? -$signed(64'(prod)) : $signed(64'(prod)));
          state <= S_BE_GO;
        end
        S_BE_GO: state <= S_BE_W;
        S_BE_W: begin
          if (c_done) begin
            beta <= c_angle;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          qa2  <= quant(QW'(alpha) - QW'(beta));
          qa3  <= quant(QW'(t3));
          qa2u <= quant(QW'(alpha) + QW'(beta));
          qa3u <= quant(-QW'(t3));
          state <= S_OUT1;
        end
        S_OUT1: begin
          if (out_free) begin
            result_valid <= 1'b1;
            base_angle <= sat(qa1);
            elbow_up <= 1'b0;
            if (eunr) begin
              status <= ST_UNREACH;
              shoulder_angle <= '0;
              elbow_angle <= '0;
              last <= 1'b1;
              state <= S_IDLE;
            end else begin
              shoulder_angle <= sat(qa2);
              elbow_angle <= sat(qa3);
              if (emode) begin
                status <= ST_OK;
                last <= 1'b0;
                state <= S_OUT2;
              end else begin
                status <= out_range ? ST_OUT_RANGE : ST_OK;
                last <= 1'b1;
                state <= S_IDLE;
              end
            end
          end
        end
        S_OUT2: begin
          if (out_free) begin
            result_valid <= 1'b1;
            status <= ST_OK;
            base_angle <= sat(qa1);
            shoulder_angle <= sat(qa2u);
            elbow_angle <= sat(qa3u);
            elbow_up <= 1'b1;
            last <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/arm_inverse_kinematics_3dof_top.sv
// Top level of the three-joint arm inverse kinematics block.
// Depends on aik_pkg, aik_front, aik_queue and aik_back.
//
// Targets (x, y, z, signed Q12.12) enter on the target_* valid/ready channel;
// joint angles (signed Q3.13 radians) leave on the result_* channel, one beat
// per result, last high on the final beat of a target. Single mode gives one
// elbow-down beat, dual mode gives elbow-down then elbow-up, and an unreachable
// target gives one beat with status 1. The user must write registers through
// config_write/config_index/config_data only while idle; the block does not enforce it.
// The front end classifies a target in a registered pipeline and parks it in a
// 4-entry queue, so targets keep being taken while the solver works. The solver
// runs one target at a time, which sets the throughput. An unreachable target
// needs only the base CORDIC pass; a reachable one needs four CORDIC passes (a
// normalise phase plus CORDIC_STEPS rotations each, skipped when an operand is
// zero), a divider and two square roots sharing one sequencer. A stalled result
// receiver holds the result register; the solver then waits, the queue fills
// and target_ready drops.
// Reset (synchronous) empties the pipeline and queue and loads base height 0,
// link lengths 4096 and single mode.
module arm_inverse_kinematics_3dof_top #(
  parameter int CORDIC_STEPS = 16,
  parameter int COORD_BITS   = 24,
  parameter int ANGLE_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          config_write,
  input  logic [1:0]                    config_index,
  input  logic [aik_pkg::LEN_W-1:0]     config_data,
  input  logic signed [COORD_BITS-1:0]  target_x,
  input  logic signed [COORD_BITS-1:0]  target_y,
  input  logic signed [COORD_BITS-1:0]  target_z,
  input  logic                          target_valid,
  output logic                          target_ready,
  output logic [1:0]                    status,
  output logic signed [ANGLE_BITS-1:0]  base_angle,
  output logic signed [ANGLE_BITS-1:0]  shoulder_angle,
  output logic signed [ANGLE_BITS-1:0]  elbow_angle,
  output logic                          elbow_up,
  output logic                          last,
  output logic                          result_valid,
  input  logic                          result_ready
);
  import aik_pkg::*;

  localparam int EW = entry_w(COORD_BITS);

  logic          push_valid, push_ready, pop_valid, pop;
  logic [EW-1:0] push_data, pop_data;

  aik_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst),
    .config_write(config_write), .config_index(config_index), .config_data(config_data),
    .target_x(target_x), .target_y(target_y), .target_z(target_z),
    .target_valid(target_valid), .target_ready(target_ready),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
  );

  aik_queue #(.W(EW)) u_queue (
    .clk(clk), .rst(rst),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
    .pop_valid(pop_valid), .pop(pop), .pop_data(pop_data)
  );

  aik_back #(
    .CORDIC_STEPS(CORDIC_STEPS), .COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS)
  ) u_back (
    .clk(clk), .rst(rst),
    .q_valid(pop_valid), .q_pop(pop), .q_data(pop_data),
    .result_valid(result_valid), .result_ready(result_ready),
    .status(status), .base_angle(base_angle), .shoulder_angle(shoulder_angle),
    .elbow_angle(elbow_angle), .elbow_up(elbow_up), .last(last)
  );

endmodule
